// ----- design/leg_pkg.sv -----
`default_nettype none

package leg_pkg;

    localparam int PHASE_PER_HZ = 6087;
    localparam int STEPS_LOG2   = 7;
    localparam int STEPS        = 1 << STEPS_LOG2;
    localparam int ROM_SIZE     = 96;
    localparam int ROM_LAST     = ROM_SIZE - 1;
    localparam int PHASE_W      = 28;
    localparam int INDEX_W      = STEPS_LOG2 + 1;
    localparam int LEVEL_W      = 11;
    localparam int ROM_AW       = 7;
    localparam int NOTE_IGNORE  = 120;
    localparam int NOTE_CLAMP   = 96;

    localparam logic [PHASE_W-1:0] PHASE_MASK = {PHASE_W{1'b1}};

    // register indexes
    localparam logic [1:0] REG_TARGET_TYPE   = 2'd0;
    localparam logic [1:0] REG_ENVELOPE_MODE = 2'd1;
    localparam logic [1:0] REG_RATE_CODE     = 2'd2;
    localparam logic [1:0] REG_KEY_SCALING   = 2'd3;

    // envelope modes
    localparam logic [3:0] MODE_CONST          = 4'd0;
    localparam logic [3:0] MODE_OUT_HOLD_END   = 4'd1;
    localparam logic [3:0] MODE_OUT_HOLD_START = 4'd2;
    localparam logic [3:0] MODE_OUT_REPEAT     = 4'd3;
    localparam logic [3:0] MODE_OUT_FLIP       = 4'd4;
    localparam logic [3:0] MODE_IN_HOLD_END    = 4'd5;
    localparam logic [3:0] MODE_IN_HOLD_START  = 4'd6;
    localparam logic [3:0] MODE_IN_REPEAT      = 4'd7;
    localparam logic [3:0] MODE_IN_FLIP        = 4'd8;

    localparam logic OP_TICK    = 1'b0;
    localparam logic OP_TRIGGER = 1'b1;

    typedef logic [PHASE_W-1:0] step_rom_t [ROM_SIZE];

    localparam logic [24:0] FREQ_Q20 [12] = '{
        25'd16777216, 25'd17774841, 25'd18831788, 25'd19951585,
        25'd21137968, 25'd22394897, 25'd23726566, 25'd25137421,
        25'd26632170, 25'd28215802, 25'd29893600, 25'd31671166
    };

    localparam logic [LEVEL_W-1:0] PITCH_DEPTH [9] = '{
        11'd128, 11'd256, 11'd448, 11'd640, 11'd768,
        11'd896, 11'd1024, 11'd1216, 11'd1408
    };

    localparam logic [LEVEL_W-1:0] PULSE_DEPTH [9] = '{
        11'd64, 11'd96, 11'd128, 11'd192, 11'd256,
        11'd320, 11'd384, 11'd416, 11'd448
    };

    localparam logic [3:0] RATE_OFFSET [4] = '{4'd0, 4'd4, 4'd7, 4'd10};

    // step = round(freq * 2^(row+2) * phase_per_hz), saturated to the phase width
    function automatic step_rom_t build_step_rom();
        step_rom_t   rom;
        logic [63:0] prod;
        logic [63:0] v;
        for (int row = 0; row < 8; row++)
        begin
            for (int semi = 0; semi < 12; semi++)
            begin
                prod = 64'(FREQ_Q20[semi]) * 64'(PHASE_PER_HZ);
                v    = (prod + (64'd1 << (17 - row))) >> (18 - row);
                rom[row * 12 + semi] = (v > 64'(PHASE_MASK)) ? PHASE_MASK : v[PHASE_W-1:0];
            end
        end
        return rom;
    endfunction

    localparam step_rom_t STEP_ROM = build_step_rom();

    // level = (depth * index + steps/2) / steps
    function automatic logic [LEVEL_W-1:0] calc_level(
        input logic               tt,
        input logic [3:0]         row,
        input logic [INDEX_W-1:0] idx
    );
        logic [3:0]         r;
        logic [LEVEL_W-1:0] d;
        logic [18:0]        prod;
        r    = (row <= 4'd8) ? row : 4'd0;
        d    = tt ? PULSE_DEPTH[r] : PITCH_DEPTH[r];
        prod = 19'(d) * 19'(idx) + 19'(STEPS / 2);
        return prod[STEPS_LOG2 +: LEVEL_W];
    endfunction

endpackage

`default_nettype wire

// ----- design/linear_envelope_generator.sv -----
`default_nettype none
// output: a result is registered from its accepted input transaction
// throughput: one item per cycle; the input stays ready while the output register
// is empty or being drained in the same cycle
// reset: all envelope state, the output valid flag and the configuration return
// to their defaults (rate code 1, key scaling 1, everything else zero); output data is not reset

module linear_envelope_generator (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [15:0] s_tdata,   // note_number[6:0], brightness[10:7], zero pad
    input  wire logic        s_tuser,   // opcode
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [15:0]      m_tdata,   // level[10:0], held[11], zero pad
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [5:0]  cfg_data
);

    logic                             target_type_reg;
    logic [3:0]                       envelope_mode_reg;
    logic [5:0]                       rate_code_reg;
    logic [3:0]                       key_scaling_reg;

    logic [leg_pkg::PHASE_W-1:0]      phase_acc_reg, phase_acc_next;
    logic [leg_pkg::PHASE_W-1:0]      phase_step_reg, phase_step_next;
    logic [leg_pkg::INDEX_W-1:0]      table_index_reg, table_index_next;
    logic                             alt_flag_reg, alt_flag_next;
    logic [3:0]                       depth_row_reg, depth_row_next;
    logic [leg_pkg::LEVEL_W-1:0]      level_reg, level_next;

    logic                             out_valid_reg;
    logic [leg_pkg::LEVEL_W-1:0]      out_level_reg;
    logic                             out_held_reg;

    logic                             accept;
    logic [6:0]                       note;
    logic [3:0]                       bright;
    logic [3:0]                       mode;
    logic [5:0]                       rate;
    logic [4:0]                       rate_m1;
    logic [3:0]                       ks;
    logic [6:0]                       note_c;
    logic [8:0]                       ks_key;
    logic [7:0]                       entry_sum;
    logic [leg_pkg::ROM_AW-1:0]       entry;
    logic [leg_pkg::PHASE_W:0]        phase_sum;
    logic signed [9:0]                idx_s;
    logic signed [9:0]                delta;
    logic                             update_level;

    assign accept    = s_tvalid && s_tready;
    assign s_tready  = !out_valid_reg || m_tready;
    assign cfg_ready = 1'b1;
    assign note      = s_tdata[6:0];
    assign bright    = s_tdata[10:7];

    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = {4'b0000, out_held_reg, out_level_reg};

    // trigger path: increment rom entry
    always_comb
    begin
        mode    = (envelope_mode_reg <= leg_pkg::MODE_IN_FLIP) ? envelope_mode_reg
                                                               : leg_pkg::MODE_CONST;
        rate    = (rate_code_reg >= 6'd1 && rate_code_reg <= 6'd32) ? rate_code_reg : 6'd1;
        rate_m1 = 5'(rate - 6'd1);
        ks      = (key_scaling_reg >= 4'd1 && key_scaling_reg <= 4'd8) ? key_scaling_reg
                                                                       : 4'd1;
        note_c  = (note > 7'(leg_pkg::NOTE_CLAMP)) ? 7'(leg_pkg::NOTE_CLAMP) : note;
        ks_key  = 9'(ks) * 9'(note_c[6:1]);
        entry_sum = 8'({rate_m1[4:2], 3'b000}) + 8'({rate_m1[4:2], 2'b00})
                  + 8'(leg_pkg::RATE_OFFSET[rate_m1[1:0]]) + 8'(ks_key[8:3]);
        entry   = (entry_sum > 8'(leg_pkg::ROM_LAST)) ? leg_pkg::ROM_AW'(leg_pkg::ROM_LAST)
                                                      : entry_sum[leg_pkg::ROM_AW-1:0];
    end

    // next envelope state
    always_comb
    begin
        phase_acc_next   = phase_acc_reg;
        phase_step_next  = phase_step_reg;
        table_index_next = table_index_reg;
        alt_flag_next    = alt_flag_reg;
        depth_row_next   = depth_row_reg;
        update_level     = 1'b0;
        phase_sum        = {1'b0, phase_acc_reg} + {1'b0, phase_step_reg};
        delta            = 10'sd0;
        idx_s            = $signed({2'b00, table_index_reg});

        if (s_tuser == leg_pkg::OP_TRIGGER)
        begin
            if (note < 7'(leg_pkg::NOTE_IGNORE))
            begin
                phase_step_next  = leg_pkg::STEP_ROM[entry];
                depth_row_next   = (bright >= 4'd1 && bright <= 4'd9) ? 4'(bright - 4'd1)
                                                                      : 4'd0;
                phase_acc_next   = '0;
                table_index_next = (mode >= leg_pkg::MODE_OUT_HOLD_END &&
                                    mode <= leg_pkg::MODE_OUT_FLIP)
                                   ? '0 : leg_pkg::INDEX_W'(leg_pkg::STEPS);
                alt_flag_next    = 1'b0;
                update_level     = 1'b1;
            end
        end
        else if (mode != leg_pkg::MODE_CONST)
        begin
            phase_acc_next = phase_sum[leg_pkg::PHASE_W-1:0];
            if (phase_sum[leg_pkg::PHASE_W])
            begin
                update_level = 1'b1;
                if (alt_flag_reg)
                begin
                    if (mode == leg_pkg::MODE_OUT_FLIP)
                        delta = -10'sd1;
                    else if (mode == leg_pkg::MODE_IN_FLIP)
                        delta = 10'sd1;
                end
                else
                begin
                    delta = (mode <= leg_pkg::MODE_OUT_FLIP) ? 10'sd1 : -10'sd1;
                end
                idx_s = idx_s + delta;
                table_index_next = idx_s[leg_pkg::INDEX_W-1:0];
                if (idx_s > 10'(leg_pkg::STEPS))
                begin
                    table_index_next = leg_pkg::INDEX_W'(leg_pkg::STEPS);
                    case (mode)
                        leg_pkg::MODE_OUT_HOLD_END:   alt_flag_next = 1'b1;
                        leg_pkg::MODE_OUT_HOLD_START:
                        begin
                            table_index_next = '0;
                            alt_flag_next    = 1'b1;
                        end
                        leg_pkg::MODE_OUT_REPEAT:     table_index_next = '0;
                        leg_pkg::MODE_OUT_FLIP:       alt_flag_next = 1'b1;
                        leg_pkg::MODE_IN_FLIP:        alt_flag_next = 1'b0;
                        default:                      alt_flag_next = alt_flag_reg;
                    endcase
                end
                else if (idx_s < 10'sd0)
                begin
                    table_index_next = '0;
                    case (mode)
                        leg_pkg::MODE_IN_HOLD_END:    alt_flag_next = 1'b1;
                        leg_pkg::MODE_IN_HOLD_START:
                        begin
                            table_index_next = leg_pkg::INDEX_W'(leg_pkg::STEPS);
                            alt_flag_next    = 1'b1;
                        end
                        leg_pkg::MODE_IN_REPEAT:
                            table_index_next = leg_pkg::INDEX_W'(leg_pkg::STEPS);
                        leg_pkg::MODE_IN_FLIP:        alt_flag_next = 1'b1;
                        leg_pkg::MODE_OUT_FLIP:       alt_flag_next = 1'b0;
                        default:                      alt_flag_next = alt_flag_reg;
                    endcase
                end
            end
        end

        level_next = update_level
                   ? leg_pkg::calc_level(target_type_reg, depth_row_next, table_index_next)
                   : level_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_type_reg   <= 1'b0;
            envelope_mode_reg <= leg_pkg::MODE_CONST;
            rate_code_reg     <= 6'd1;
            key_scaling_reg   <= 4'd1;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                leg_pkg::REG_TARGET_TYPE:   target_type_reg   <= cfg_data[0];
                leg_pkg::REG_ENVELOPE_MODE: envelope_mode_reg <= cfg_data[3:0];
                leg_pkg::REG_RATE_CODE:     rate_code_reg     <= cfg_data;
                leg_pkg::REG_KEY_SCALING:   key_scaling_reg   <= cfg_data[3:0];
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_acc_reg   <= '0;
            phase_step_reg  <= '0;
            table_index_reg <= '0;
            alt_flag_reg    <= 1'b0;
            depth_row_reg   <= '0;
            level_reg       <= '0;
        end
        else if (accept)
        begin
            phase_acc_reg   <= phase_acc_next;
            phase_step_reg  <= phase_step_next;
            table_index_reg <= table_index_next;
            alt_flag_reg    <= alt_flag_next;
            depth_row_reg   <= depth_row_next;
            level_reg       <= level_next;
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            out_level_reg <= level_next;
            out_held_reg  <= alt_flag_next;
        end
    end

endmodule

`default_nettype wire
